### hw/rtl/dsc_pkg.sv
`timescale 1ns / 1ps

package dsc_pkg;

  // Quotient bits of the sine divide: the scaled sine never exceeds 1024.
  localparam int unsigned QBITS      = 11;
  // Fraction bits the sine is scaled by, and the coordinate pre-scale.
  localparam int unsigned SINE_SHIFT = 10;
  localparam int unsigned SCALE_SHIFT = 6;
  localparam int unsigned TAB_N      = 32;
  localparam int unsigned SECT_LAST  = 63;
  localparam int unsigned SECT_N     = 64;
  localparam int unsigned SECT_HALF  = 32;

  typedef logic signed [11:0] sine_t;
  typedef logic signed [6:0]  dir_t;

  localparam dir_t DIR_NONE = -7'sd1;

  localparam sine_t SINE_TAB [TAB_N] = '{
    12'sd1024, 12'sd1019, 12'sd1004, 12'sd979, 12'sd946, 12'sd903, 12'sd851, 12'sd791,
    12'sd724,  12'sd649,  12'sd568,  12'sd482, 12'sd391, 12'sd297, 12'sd199, 12'sd100,
    12'sd0,    -12'sd100, -12'sd199, -12'sd297, -12'sd391, -12'sd482, -12'sd568, -12'sd649,
    -12'sd724, -12'sd791, -12'sd851, -12'sd903, -12'sd946, -12'sd979, -12'sd1004, -12'sd1019
  };

  // Per-vector flags that ride along the cell chain.
  typedef struct packed {
    logic coin;      // points coincide
    logic a_nonneg;  // dx >= 0
    logic b_neg;     // dy < 0
  } vec_flags_t;

endpackage

### hw/rtl/dsc_if.sv
`timescale 1ns / 1ps

interface dsc_in_if #(
  parameter int unsigned CoordBits = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] origin_x;
  logic signed [CoordBits-1:0] origin_y;
  logic signed [CoordBits-1:0] target_x;
  logic signed [CoordBits-1:0] target_y;
  logic signed [CoordBits-1:0] probe_x;
  logic signed [CoordBits-1:0] probe_y;

  modport source (output valid, origin_x, origin_y, target_x, target_y, probe_x, probe_y,
                  input ready);
  modport sink   (input valid, origin_x, origin_y, target_x, target_y, probe_x, probe_y,
                  output ready);
endinterface

interface dsc_out_if;
  logic              valid;
  logic              ready;
  logic signed [6:0] target_dir;
  logic signed [6:0] probe_dir;
  logic        [5:0] dir_difference;
  logic        [6:0] dir_angle;

  modport source (output valid, target_dir, probe_dir, dir_difference, dir_angle,
                  input ready);
  modport sink   (input valid, target_dir, probe_dir, dir_difference, dir_angle,
                  output ready);
endinterface

### hw/rtl/dsc_sqrt_cell.sv
`timescale 1ns / 1ps

// One root bit of a restoring square root: take two radicand bits, try to subtract.
module dsc_sqrt_cell #(
  parameter int unsigned RadW  = 46,
  parameter int unsigned RootW = 23,
  parameter int unsigned RemW  = 26
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [RadW-1:0]  rad_i,
  input  logic [RemW-1:0]  rem_i,
  input  logic [RootW-1:0] root_i,
  output logic [RadW-1:0]  rad_o,
  output logic [RemW-1:0]  rem_o,
  output logic [RootW-1:0] root_o
);
  logic [RemW-1:0]  cur;
  logic [RemW-1:0]  trial;
  logic             ge;
  logic [RadW-1:0]  rad_d, rad_q;
  logic [RemW-1:0]  rem_d, rem_q;
  logic [RootW-1:0] root_d, root_q;

  always_comb begin
    cur    = {rem_i[RemW-3:0], rad_i[RadW-1 -: 2]};
    trial  = RemW'({root_i, 2'b01});
    ge     = (cur >= trial);
    rem_d  = ge ? (cur - trial) : cur;
    root_d = {root_i[RootW-2:0], ge};
    rad_d  = rad_i << 2;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
endmodule

### hw/rtl/dsc_div_cell.sv
`timescale 1ns / 1ps

// One quotient bit of a restoring divide: compare against the shifted divisor.
module dsc_div_cell #(
  parameter int unsigned NumW  = 33,
  parameter int unsigned DivW  = 23,
  parameter int unsigned QW    = 11,
  parameter int unsigned Shift = 10
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NumW-1:0] rem_i,
  input  logic [DivW-1:0] div_i,
  input  logic [QW-1:0]   quot_i,
  output logic [NumW-1:0] rem_o,
  output logic [DivW-1:0] div_o,
  output logic [QW-1:0]   quot_o
);
  logic [NumW-1:0] sub;
  logic            ge;
  logic [NumW-1:0] rem_d, rem_q;
  logic [DivW-1:0] div_q;
  logic [QW-1:0]   quot_d, quot_q;

  always_comb begin
    sub    = NumW'(div_i) << Shift;
    ge     = (rem_i >= sub);
    rem_d  = ge ? (rem_i - sub) : rem_i;
    quot_d = {quot_i[QW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      div_q  <= div_i;
      quot_q <= quot_d;
    end
  end

  assign rem_o  = rem_q;
  assign div_o  = div_q;
  assign quot_o = quot_q;
endmodule

### hw/rtl/dsc_sector.sv
`timescale 1ns / 1ps

// Locate the signed sine in the table and fold it into a sector.
module dsc_sector (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [dsc_pkg::QBITS-1:0] quot_i,
  input  dsc_pkg::vec_flags_t      flags_i,
  output dsc_pkg::dir_t            dir_o
);
  import dsc_pkg::*;

  sine_t      sn;
  logic [5:0] cnt;
  logic [4:0] r;
  logic       comp;
  dir_t       dir_d, dir_q;

  always_comb begin
    sn  = flags_i.b_neg ? -sine_t'(quot_i) : sine_t'(quot_i);
    cnt = '0;
    for (int i = 0; i < TAB_N; i++) begin
      cnt = cnt + 6'(SINE_TAB[i] >= sn);
    end
    r    = 5'(cnt - 6'd1);
    comp = (r != 5'(TAB_N - 1)) && (sn == SINE_TAB[r]);
    if (flags_i.coin) begin
      dir_d = DIR_NONE;
    end else if ((r != '0) && flags_i.a_nonneg) begin
      dir_d = dir_t'(7'(SECT_LAST) - 7'(r) + 7'(comp));
    end else begin
      dir_d = dir_t'({2'b00, r});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dir_q <= dir_d;
    end
  end

  assign dir_o = dir_q;
endmodule

### hw/rtl/direction_sector_compare.sv
`timescale 1ns / 1ps

// Throughput: one word per cycle; the whole chain advances together, so a stalled output
//   holds every stage and drops ready until the output word is taken.
// Reset: asynchronous, active low; clears only the valid flags, payload is don't-care.
module direction_sector_compare #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dsc_in_if.sink     in_i,
  dsc_out_if.source  out_o
);
  import dsc_pkg::*;

  // Widths of the datapath, all following the coordinate width.
  localparam int unsigned DW    = COORD_BITS + 1;             // coordinate difference
  localparam int unsigned SUMW  = 2 * DW;                     // dx^2 + dy^2
  localparam int unsigned RADW  = SUMW + 2 * SCALE_SHIFT;     // scaled by 64 squared
  localparam int unsigned SQN   = RADW / 2;                   // root bits, one cell each
  localparam int unsigned REMW  = SQN + 3;
  localparam int unsigned NUMW  = DW + SCALE_SHIFT + SINE_SHIFT;
  // Stage map: 0 diffs, 1 radicand, sqrt cells, divide cells, sector, output.
  localparam int unsigned DIV0  = SQN + 2;
  localparam int unsigned SEC   = DIV0 + QBITS;
  localparam int unsigned LAST  = SEC + 1;

  logic            en;
  logic [LAST:0]   v_q;

  // Advance everything when the output register is free or being drained.
  assign en         = !v_q[LAST] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAST-1:0], in_i.valid};
    end
  end

  // Lane 0 is origin->target, lane 1 origin->probe.
  logic signed [COORD_BITS-1:0] px [2];
  logic signed [COORD_BITS-1:0] py [2];
  assign px[0] = in_i.target_x;
  assign py[0] = in_i.target_y;
  assign px[1] = in_i.probe_x;
  assign py[1] = in_i.probe_y;

  logic signed [DW-1:0] a_q [2];
  logic signed [DW-1:0] b_q [2];
  logic [RADW-1:0]      rad_q [2];
  dir_t                 dir [2];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic signed [DW-1:0]   a_d, b_d;
    logic signed [SUMW-1:0] sqa, sqb;
    logic [SUMW-1:0]        sum;
    logic [RADW-1:0]        rad   [SQN+1];
    logic [REMW-1:0]        rem   [SQN+1];
    logic [SQN-1:0]         root  [SQN+1];
    logic [NUMW-1:0]        nrem  [QBITS+1];
    logic [SQN-1:0]         dv    [QBITS+1];
    logic [QBITS-1:0]       quot  [QBITS+1];
    vec_flags_t             flags_q [SEC];
    logic [DW-1:0]          bmag_q  [DIV0];

    always_comb begin
      a_d = DW'(px[l]) - DW'(in_i.origin_x);
      b_d = DW'(py[l]) - DW'(in_i.origin_y);
      sqa = a_q[l] * a_q[l];
      sqb = b_q[l] * b_q[l];
      sum = $unsigned(sqa) + $unsigned(sqb);
    end

    // Capture differences and the flags that travel with them.
    always_ff @(posedge clk_i) begin
      if (en) begin
        a_q[l]     <= a_d;
        b_q[l]     <= b_d;
        flags_q[0] <= '{coin:     (a_d == '0) && (b_d == '0),
                        a_nonneg: !a_d[DW-1],
                        b_neg:    b_d[DW-1]};
        bmag_q[0]  <= b_d[DW-1] ? $unsigned(-b_d) : $unsigned(b_d);
        rad_q[l]   <= {sum, {(2 * SCALE_SHIFT){1'b0}}};
        // Sideband shift lines alongside the cells.
        for (int s = 1; s < SEC; s++) begin
          flags_q[s] <= flags_q[s-1];
        end
        for (int s = 1; s < DIV0; s++) begin
          bmag_q[s] <= bmag_q[s-1];
        end
      end
    end

    assign rad[0]  = rad_q[l];
    assign rem[0]  = '0;
    assign root[0] = '0;

    for (genvar k = 0; k < SQN; k++) begin : g_sqrt
      dsc_sqrt_cell #(.RadW(RADW), .RootW(SQN), .RemW(REMW)) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .rad_i (rad[k]),
        .rem_i (rem[k]),
        .root_i(root[k]),
        .rad_o (rad[k+1]),
        .rem_o (rem[k+1]),
        .root_o(root[k+1])
      );
    end

    // Numerator is |dy| * 64 * 1024; quotient magnitude never exceeds 1024.
    assign nrem[0] = {bmag_q[DIV0-1], {(SCALE_SHIFT + SINE_SHIFT){1'b0}}};
    assign dv[0]   = root[SQN];
    assign quot[0] = '0;

    for (genvar k = 0; k < QBITS; k++) begin : g_div
      dsc_div_cell #(.NumW(NUMW), .DivW(SQN), .QW(QBITS), .Shift(QBITS - 1 - k)) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .rem_i (nrem[k]),
        .div_i (dv[k]),
        .quot_i(quot[k]),
        .rem_o (nrem[k+1]),
        .div_o (dv[k+1]),
        .quot_o(quot[k+1])
      );
    end

    dsc_sector u_sector (
      .clk_i  (clk_i),
      .en_i   (en),
      .quot_i (quot[QBITS]),
      .flags_i(flags_q[SEC-1]),
      .dir_o  (dir[l])
    );
  end

  // Output stage: wrap the difference, then fold it.
  logic signed [7:0] diff;
  logic [6:0]        ang_d, ang_q;
  logic [5:0]        dif_d, dif_q;
  dir_t              td_q, pd_q;

  always_comb begin
    diff  = 8'(dir[0]) - 8'(dir[1]);
    ang_d = diff[7] ? 7'(diff + 8'sd64) : 7'(diff);
    dif_d = (ang_d > 7'(SECT_HALF)) ? 6'(7'(SECT_N) - ang_d) : 6'(ang_d);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      td_q  <= dir[0];
      pd_q  <= dir[1];
      ang_q <= ang_d;
      dif_q <= dif_d;
    end
  end

  assign out_o.valid          = v_q[LAST];
  assign out_o.target_dir     = td_q;
  assign out_o.probe_dir      = pd_q;
  assign out_o.dir_difference = dif_q;
  assign out_o.dir_angle      = ang_q;

`ifndef ASSERT_OFF
  a_ang_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.dir_angle <= 7'd64) && (out_o.dir_difference <= 6'd32))
    else $error("angle or difference out of range");
  a_same_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.target_dir == out_o.probe_dir)) |-> (out_o.dir_difference == 6'd0))
    else $error("equal sectors give nonzero difference");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("input stalled without output backpressure");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> out_o.valid)
    else $error("output word dropped while stalled");
`endif
endmodule
